/* rtl/ufb_pkg.sv */
// Shared types and constants for the framed UART byte buffer.
// Used by ufb_front, ufb_back and framed_uart_byte_buffer_top; no dependencies.
package ufb_pkg;

    // default ring depths; each ring holds depth minus one bytes
    localparam int RX_DEPTH_DEF = 64;
    localparam int TX_DEPTH_DEF = 64;

    // entries in the front-to-back queue
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOOTER_VALUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT    = 3'd4;

    localparam logic [7:0] LINE_LIMIT_RESET = 8'd64;

    // action codes of an input item
    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_SERVICE = 2'd1,
        CMD_LINE    = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    // classified item as it travels from front to back
    typedef struct packed {
        cmd_t       cmd;
        logic       char_end;
        logic [7:0] send_char;
        logic       rx_ready;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } op_t;

    typedef struct packed {
        logic       header_enable;
        logic [7:0] header_value;
        logic       footer_enable;
        logic [7:0] footer_value;
        logic [7:0] line_limit;
    } cfg_t;

    typedef struct packed {
        logic       char_taken;
        logic       message_done;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_active;
        logic       rx_dropped;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       store_valid;
        logic [7:0] store_index;
        logic       line_done;
        logic [7:0] line_length;
    } res_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } bk_state_t;

endpackage

/* rtl/ufb_front.sv */
// Front end: accepts input items, classifies them and holds them in a short queue.
// Depends on ufb_pkg.
module ufb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     action,
    input  logic [7:0]     send_char,
    input  logic           rx_ready,
    input  logic [7:0]     rx_byte,
    input  logic           tx_ready,
    output ufb_pkg::op_t   q_op,
    output logic           q_valid,
    input  logic           q_pop
);
    import ufb_pkg::*;

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QA_W-1:0] Q_LAST = QA_W'(QUEUE_DEPTH - 1);
    localparam logic [QC_W-1:0] Q_FULL = QC_W'(QUEUE_DEPTH);

    op_t             q_mem [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QC_W-1:0] count_reg, count_next;
    op_t             op_in;
    logic            push;

    always_comb
    begin
        op_in.cmd       = cmd_t'(action);
        op_in.char_end  = (send_char == 8'd0);
        op_in.send_char = send_char;
        op_in.rx_ready  = rx_ready;
        op_in.rx_byte   = rx_byte;
        op_in.tx_ready  = tx_ready;
    end

    assign in_stall = (count_reg == Q_FULL);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_op     = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= op_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/ufb_back.sv */
// Back end: owns both byte rings, the framing and line state, and the output register.
// Depends on ufb_pkg; fed by ufb_front.
module ufb_back #(
    parameter int RX_DEPTH = ufb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ufb_pkg::TX_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ufb_pkg::cfg_t  cfg,
    input  ufb_pkg::op_t   q_op,
    input  logic           q_valid,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_stall,
    output ufb_pkg::res_t  res
);
    import ufb_pkg::*;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    logic [7:0] rx_ring [RX_DEPTH];
    logic [7:0] tx_ring [TX_DEPTH];
    logic [7:0] rx_rdata_reg;
    logic [7:0] tx_rdata_reg;

    bk_state_t        state_reg, state_next;
    op_t              op_reg;
    logic [RX_AW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic             tx_busy_reg, tx_busy_next;
    logic             header_done_reg, header_done_next;
    logic             footer_done_reg, footer_done_next;
    logic [7:0]       line_count_reg, line_count_next;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg, res_next;

    logic             out_free;
    logic             exec_en;
    logic             rx_we, tx_we;
    logic [7:0]       tx_wdata;
    logic [RX_AW-1:0] rx_tail_inc, rx_head_inc;
    logic [TX_AW-1:0] tx_tail_inc, tx_head_inc;
    logic             rx_full, rx_empty, tx_full, tx_empty;
    logic [7:0]       thr;
    logic [7:0]       cnt;
    res_t             r;

    assign out_free = !out_valid_reg || !out_stall;

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        q_pop   = 1'b0;
        exec_en = 1'b0;
        unique case (state_reg)
            BK_IDLE: q_pop   = q_valid && out_free;
            BK_EXEC: exec_en = 1'b1;
        endcase
    end

    assign rx_tail_inc = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
    assign rx_full     = (rx_tail_inc == rx_head_reg);
    assign tx_full     = (tx_tail_inc == tx_head_reg);
    assign rx_empty    = (rx_tail_reg == rx_head_reg);
    assign tx_empty    = (tx_tail_reg == tx_head_reg);
    assign thr         = cfg.line_limit - 8'd1;

    always_comb
    begin
        rx_head_next     = rx_head_reg;
        rx_tail_next     = rx_tail_reg;
        tx_head_next     = tx_head_reg;
        tx_tail_next     = tx_tail_reg;
        tx_busy_next     = tx_busy_reg;
        header_done_next = header_done_reg;
        footer_done_next = footer_done_reg;
        line_count_next  = line_count_reg;
        rx_we            = 1'b0;
        tx_we            = 1'b0;
        tx_wdata         = op_reg.send_char;
        cnt              = line_count_reg;
        r                = '0;
        if (exec_en)
        begin
            unique case (op_reg.cmd)
                CMD_SEND:
                begin
                    if (cfg.header_enable && !header_done_reg)
                    begin
                        // a header that does not fit is lost
                        if (!tx_full)
                        begin
                            tx_we        = 1'b1;
                            tx_wdata     = cfg.header_value;
                            tx_tail_next = tx_tail_inc;
                            tx_busy_next = 1'b1;
                        end
                        header_done_next = 1'b1;
                    end
                    else if (!op_reg.char_end)
                    begin
                        // a character that does not fit is offered again
                        if (!tx_full)
                        begin
                            tx_we        = 1'b1;
                            tx_tail_next = tx_tail_inc;
                            r.char_taken = 1'b1;
                        end
                        tx_busy_next = 1'b1;
                    end
                    else if (cfg.footer_enable && !footer_done_reg)
                    begin
                        if (!tx_full)
                        begin
                            tx_we        = 1'b1;
                            tx_wdata     = cfg.footer_value;
                            tx_tail_next = tx_tail_inc;
                            tx_busy_next = 1'b1;
                        end
                        footer_done_next = 1'b1;
                    end
                    else
                    begin
                        header_done_next = 1'b0;
                        footer_done_next = 1'b0;
                        r.message_done   = 1'b1;
                    end
                end
                CMD_SERVICE:
                begin
                    if (op_reg.rx_ready)
                    begin
                        if (rx_full)
                        begin
                            r.rx_dropped = 1'b1;
                        end
                        else
                        begin
                            rx_we        = 1'b1;
                            rx_tail_next = rx_tail_inc;
                        end
                    end
                    if (op_reg.tx_ready)
                    begin
                        if (!tx_empty)
                        begin
                            r.tx_valid   = 1'b1;
                            r.tx_byte    = tx_rdata_reg;
                            tx_head_next = tx_head_inc;
                        end
                        else
                        begin
                            tx_busy_next = 1'b0;
                        end
                    end
                end
                CMD_LINE:
                begin
                    if (!rx_empty)
                    begin
                        r.read_valid = 1'b1;
                        r.read_byte  = rx_rdata_reg;
                        rx_head_next = rx_head_inc;
                        if (line_count_reg < thr)
                        begin
                            r.store_valid = 1'b1;
                            r.store_index = line_count_reg;
                            cnt           = line_count_reg + 8'd1;
                        end
                        // zero byte or full line closes it
                        if ((cnt >= thr) || (rx_rdata_reg == 8'd0))
                        begin
                            r.line_done     = 1'b1;
                            r.line_length   = cnt;
                            line_count_next = 8'd0;
                        end
                        else
                        begin
                            line_count_next = cnt;
                        end
                    end
                end
                CMD_READ:
                begin
                    if (!rx_empty)
                    begin
                        r.read_valid = 1'b1;
                        r.read_byte  = rx_rdata_reg;
                        rx_head_next = rx_head_inc;
                    end
                end
            endcase
            r.tx_active = tx_busy_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (exec_en)
        begin
            out_valid_next = 1'b1;
            res_next       = r;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // rings: one write port each, registered read at the head
    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_ring[rx_tail_reg] <= op_reg.rx_byte;
        end
        rx_rdata_reg <= rx_ring[rx_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_ring[tx_tail_reg] <= tx_wdata;
        end
        tx_rdata_reg <= tx_ring[tx_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_op;
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            rx_head_reg     <= '0;
            rx_tail_reg     <= '0;
            tx_head_reg     <= '0;
            tx_tail_reg     <= '0;
            tx_busy_reg     <= 1'b0;
            header_done_reg <= 1'b0;
            footer_done_reg <= 1'b0;
            line_count_reg  <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rx_head_reg     <= rx_head_next;
            rx_tail_reg     <= rx_tail_next;
            tx_head_reg     <= tx_head_next;
            tx_tail_reg     <= tx_tail_next;
            tx_busy_reg     <= tx_busy_next;
            header_done_reg <= header_done_next;
            footer_done_reg <= footer_done_next;
            line_count_reg  <= line_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

/* rtl/framed_uart_byte_buffer_top.sv */
// Framed UART byte buffer: configuration registers, front queue and ring back end.
// Depends on ufb_pkg, ufb_front and ufb_back.

// The block keeps a receive ring and a transmit ring of bytes, each holding its
// depth minus one bytes, and runs one step per input transfer: a message send
// step (header, characters, footer, then a done report), an interrupt service
// (store a received byte, hand the next byte to the transmitter), a line read
// step or a single byte read. Every step gives exactly one result transfer.
// Input transfers go into a two-entry queue, so the input side keeps taking
// items while a result waits on a stalled output, until the queue is full.
// The back end works on one item at a time: an idle state pops the queue
// while both rings are read at their head pointers (the ring memories have a
// registered read port), and an execute state runs the step and loads the
// output register. The next item is popped only after that, once the output
// register is free. No clearing pass is needed after reset. Configuration
// writes go straight to the registers; the user must make them only while no
// item is in flight, as the block itself does not enforce this.
module framed_uart_byte_buffer_top #(
    parameter int RX_DEPTH = ufb_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = ufb_pkg::TX_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [ufb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [7:0]                    send_char,
    input  logic                          rx_ready,
    input  logic [7:0]                    rx_byte,
    input  logic                          tx_ready,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          char_taken,
    output logic                          message_done,
    output logic                          tx_valid,
    output logic [7:0]                    tx_byte,
    output logic                          tx_active,
    output logic                          rx_dropped,
    output logic                          read_valid,
    output logic [7:0]                    read_byte,
    output logic                          store_valid,
    output logic [7:0]                    store_index,
    output logic                          line_done,
    output logic [7:0]                    line_length
);
    import ufb_pkg::*;

    cfg_t cfg_reg;
    op_t  q_op;
    logic q_valid;
    logic q_pop;
    res_t res;

    // register file; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_enable <= 1'b0;
            cfg_reg.header_value  <= 8'd0;
            cfg_reg.footer_enable <= 1'b0;
            cfg_reg.footer_value  <= 8'd0;
            cfg_reg.line_limit    <= LINE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_ENABLE: cfg_reg.header_enable <= cfg_data[0];
                REG_HEADER_VALUE:  cfg_reg.header_value  <= cfg_data;
                REG_FOOTER_ENABLE: cfg_reg.footer_enable <= cfg_data[0];
                REG_FOOTER_VALUE:  cfg_reg.footer_value  <= cfg_data;
                REG_LINE_LIMIT:    cfg_reg.line_limit    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front: accept, classify, queue
    ufb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .send_char (send_char),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .tx_ready  (tx_ready),
        .q_op      (q_op),
        .q_valid   (q_valid),
        .q_pop     (q_pop)
    );

    // back: rings, framing, line count, output register
    ufb_back #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_op      (q_op),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign char_taken   = res.char_taken;
    assign message_done = res.message_done;
    assign tx_valid     = res.tx_valid;
    assign tx_byte      = res.tx_byte;
    assign tx_active    = res.tx_active;
    assign rx_dropped   = res.rx_dropped;
    assign read_valid   = res.read_valid;
    assign read_byte    = res.read_byte;
    assign store_valid  = res.store_valid;
    assign store_index  = res.store_index;
    assign line_done    = res.line_done;
    assign line_length  = res.line_length;

endmodule

/* bench/framed_uart_byte_buffer_tb.sv */
// Self-checking bench for framed_uart_byte_buffer_top: directed and random steps,
// checked against a built-in model of both rings and the send and line logic.
// Depends on ufb_pkg and framed_uart_byte_buffer_top.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufb_pkg::*;

    localparam int RX_SLOTS     = RX_DEPTH_DEF;
    localparam int TX_SLOTS     = TX_DEPTH_DEF;
    localparam int RX_AW        = $clog2(RX_SLOTS);
    localparam int TX_AW        = $clog2(TX_SLOTS);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_SLOTS - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_SLOTS - 1);
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer before giving up
    localparam int SETTLE_TAIL  = 8;
    localparam int PHASE_COUNT  = 10;
    // an index past the register list; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    // traffic mix of one random phase
    typedef enum int {
        MIX_MESSAGES,
        MIX_TX_FLOOD,
        MIX_RX_FLOOD,
        MIX_LINES,
        MIX_NOISE
    } mix_t;

    // one input step as driven on the ports
    typedef struct packed {
        cmd_t       action;
        logic [7:0] send_char;
        logic       rx_ready;
        logic [7:0] rx_byte;
        logic       tx_ready;
    } step_t;

    // Model of the two rings, the framing flags and the line counter, plus the
    // queue of results still owed by the block.
    class ring_scoreboard;
        cfg_t             regs;
        logic [7:0]       rx_ring [RX_SLOTS];
        logic [7:0]       tx_ring [TX_SLOTS];
        logic [RX_AW-1:0] rx_head, rx_tail;
        logic [TX_AW-1:0] tx_head, tx_tail;
        bit               tx_busy, header_done, footer_done;
        logic [7:0]       line_count;
        res_t             awaited [$];
        int               mismatches, checked;
        int               rx_drops, tx_refusals, lines_ended, messages_ended, tx_handed;

        function new();
            regs            = '0;
            regs.line_limit = LINE_LIMIT_RESET;
            rx_head = '0; rx_tail = '0; tx_head = '0; tx_tail = '0;
            tx_busy = 1'b0; header_done = 1'b0; footer_done = 1'b0;
            line_count = '0;
            mismatches = 0; checked = 0;
            rx_drops = 0; tx_refusals = 0; lines_ended = 0;
            messages_ended = 0; tx_handed = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                REG_HEADER_ENABLE: regs.header_enable = data[0];
                REG_HEADER_VALUE:  regs.header_value  = data;
                REG_FOOTER_ENABLE: regs.footer_enable = data[0];
                REG_FOOTER_VALUE:  regs.footer_value  = data;
                REG_LINE_LIMIT:    regs.line_limit    = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // one slot always stays free so full and empty differ
        function bit tx_push(logic [7:0] b);
            logic [TX_AW-1:0] nxt;
            nxt = (tx_tail == TX_LAST) ? '0 : tx_tail + 1'b1;
            if (nxt == tx_head)
                return 1'b0;
            tx_ring[tx_tail] = b;
            tx_tail = nxt;
            return 1'b1;
        endfunction

        function bit rx_pop(output logic [7:0] b);
            b = '0;
            if (rx_tail == rx_head)
                return 1'b0;
            b = rx_ring[rx_head];
            rx_head = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
            return 1'b1;
        endfunction

        // works out the result of an accepted step and queues it
        function res_t predict_step(step_t s);
            res_t             r;
            logic [7:0]       b;
            logic [7:0]       thr;
            logic [RX_AW-1:0] nxt;
            r = '0;
            case (s.action)
                CMD_SEND: begin
                    if (regs.header_enable && !header_done) begin
                        // a header that does not fit is lost
                        if (tx_push(regs.header_value))
                            tx_busy = 1'b1;
                        header_done = 1'b1;
                    end else if (s.send_char != 8'd0) begin
                        if (tx_push(s.send_char))
                            r.char_taken = 1'b1;
                        else
                            tx_refusals++;
                        tx_busy = 1'b1;
                    end else if (regs.footer_enable && !footer_done) begin
                        if (tx_push(regs.footer_value))
                            tx_busy = 1'b1;
                        footer_done = 1'b1;
                    end else begin
                        header_done    = 1'b0;
                        footer_done    = 1'b0;
                        r.message_done = 1'b1;
                        messages_ended++;
                    end
                end
                CMD_SERVICE: begin
                    if (s.rx_ready) begin
                        nxt = (rx_tail == RX_LAST) ? '0 : rx_tail + 1'b1;
                        if (nxt == rx_head) begin
                            r.rx_dropped = 1'b1;
                            rx_drops++;
                        end else begin
                            rx_ring[rx_tail] = s.rx_byte;
                            rx_tail = nxt;
                        end
                    end
                    if (s.tx_ready) begin
                        if (tx_tail != tx_head) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = tx_ring[tx_head];
                            tx_head    = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;
                            tx_handed++;
                        end else begin
                            tx_busy = 1'b0;
                        end
                    end
                end
                CMD_LINE: begin
                    if (rx_pop(b)) begin
                        thr         = regs.line_limit - 8'd1;  // limit 0 wraps to 255
                        r.read_valid = 1'b1;
                        r.read_byte  = b;
                        if (line_count < thr) begin
                            r.store_valid = 1'b1;
                            r.store_index = line_count;
                            line_count    = line_count + 8'd1;
                        end
                        if (line_count >= thr || b == 8'd0) begin
                            r.line_done   = 1'b1;
                            r.line_length = line_count;
                            line_count    = '0;
                            lines_ended++;
                        end
                    end
                end
                default: begin
                    if (rx_pop(b)) begin
                        r.read_valid = 1'b1;
                        r.read_byte  = b;
                    end
                end
            endcase
            r.tx_active = tx_busy;
            awaited.push_back(r);
            return r;
        endfunction

        function void compare_byte(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t ns: result %0d field %s expected %0d, got %0d",
                         $time, checked, name, want, got);
            end
        endfunction

        function void compare_flag(string name, logic want, logic got);
            if (want !== got) begin
                mismatches++;
                $display("%0t ns: result %0d field %s expected %0d, got %0d",
                         $time, checked, name, want, got);
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                $display("%0t ns: result transfer with nothing expected, got %h",
                         $time, got);
                return;
            end
            want = awaited.pop_front();
            compare_flag("char_taken",   want.char_taken,   got.char_taken);
            compare_flag("message_done", want.message_done, got.message_done);
            compare_flag("tx_valid",     want.tx_valid,     got.tx_valid);
            compare_byte("tx_byte",      want.tx_byte,      got.tx_byte);
            compare_flag("tx_active",    want.tx_active,    got.tx_active);
            compare_flag("rx_dropped",   want.rx_dropped,   got.rx_dropped);
            compare_flag("read_valid",   want.read_valid,   got.read_valid);
            compare_byte("read_byte",    want.read_byte,    got.read_byte);
            compare_flag("store_valid",  want.store_valid,  got.store_valid);
            compare_byte("store_index",  want.store_index,  got.store_index);
            compare_flag("line_done",    want.line_done,    got.line_done);
            compare_byte("line_length",  want.line_length,  got.line_length);
            checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Ports of the block; all inputs start at known values
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [1:0]           action    = '0;
    logic [7:0]           send_char = '0;
    logic                 rx_ready  = 1'b0;
    logic [7:0]           rx_byte   = '0;
    logic                 tx_ready  = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 char_taken, message_done, tx_valid, tx_active;
    logic                 rx_dropped, read_valid, store_valid, line_done;
    logic [7:0]           tx_byte, read_byte, store_index, line_length;

    res_t           seen_result;
    ring_scoreboard board;
    bit             in_idle  = 1'b1;   // sender draws gaps
    bit             out_idle = 1'b1;   // receiver draws stalls
    int             items_sent = 0;
    int             steps_of [4] = '{0, 0, 0, 0};
    int             hold_left = 0;
    int             quiet = 0;

    framed_uart_byte_buffer_top dut (.*);

    always #6 clk = ~clk;

    // result fields packed in the same order as res_t
    assign seen_result = {char_taken, message_done, tx_valid, tx_byte, tx_active,
                          rx_dropped, read_valid, read_byte, store_valid, store_index,
                          line_done, line_length};

    // ------------------------------------------------------------------
    // Result side: check every transfer, then draw how long to stall.
    // Values read right after the edge are still the pre-edge ones, since
    // every input changes by nonblocking assignment.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            board.check_result(seen_result);
            hold_left = out_idle ? $urandom_range(0, 7) : 0;
        end
        out_stall <= (hold_left != 0);
        if (hold_left != 0)
            hold_left--;
    end

    // Watchdog: a long run of cycles with no transfer on either side means
    // the block has hung or lost a result.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet == QUIET_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                         $time, QUIET_LIMIT, board.pending());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offers one step and returns once it is transferred. Valid is left high,
    // so a following step with no gap is offered at the very next edge.
    task automatic push_item(input step_t s, output res_t predicted);
        int gap;
        gap = in_idle ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= s.action;
        send_char <= s.send_char;
        rx_ready  <= s.rx_ready;
        rx_byte   <= s.rx_byte;
        tx_ready  <= s.tx_ready;
        do @(posedge clk); while (in_stall);
        predicted = board.predict_step(s);
        items_sent++;
        steps_of[s.action]++;
    endtask

    // stops offering and waits for every owed result
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // writes all five registers and the spare index; upper bits of the
    // enable writes are noise the block must ignore
    task automatic write_settings(cfg_t c);
        logic [7:0] junk;
        junk = 8'($urandom);
        reg_write(REG_HEADER_ENABLE, {junk[7:1], c.header_enable});
        reg_write(REG_HEADER_VALUE, c.header_value);
        junk = 8'($urandom);
        reg_write(REG_FOOTER_ENABLE, {junk[7:1], c.footer_enable});
        reg_write(REG_FOOTER_VALUE, c.footer_value);
        reg_write(REG_LINE_LIMIT, c.line_limit);
        junk = 8'($urandom);
        reg_write(REG_SPARE, junk);
        cfg_we <= 1'b0;
    endtask

    function automatic step_t random_step(cmd_t c);
        step_t s;
        s.action    = c;
        s.send_char = 8'($urandom_range(0, 255));
        s.rx_ready  = 1'($urandom_range(0, 1));
        s.rx_byte   = 8'($urandom_range(0, 255));
        s.tx_ready  = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic direct(cmd_t c, logic [7:0] ch, logic rr, logic [7:0] rb, logic tr);
        step_t s;
        res_t  r;
        s = '{action: c, send_char: ch, rx_ready: rr, rx_byte: rb, tx_ready: tr};
        push_item(s, r);
    endtask

    // A message the way a caller sends it: keep offering the current
    // character until it is taken, then the terminator until the block says
    // done. Service steps are mixed in so the transmit ring drains. The
    // message is cut short once the phase has sent its share of items.
    task automatic send_message(int len, int svc_pct, int txr_pct, int stop);
        step_t      s;
        res_t       r;
        logic [7:0] cur;
        int         taken, guard;
        bit         finished;
        cur      = 8'($urandom_range(1, 255));
        taken    = 0;
        guard    = 0;
        finished = 1'b0;
        while (!finished && guard < 400 && items_sent < stop) begin
            guard++;
            if ($urandom_range(0, 99) < svc_pct) begin
                s          = random_step(CMD_SERVICE);
                s.tx_ready = ($urandom_range(0, 99) < txr_pct);
                push_item(s, r);
            end else begin
                s           = random_step(CMD_SEND);
                s.send_char = (taken < len) ? cur : 8'd0;
                push_item(s, r);
                if (r.char_taken) begin
                    taken++;
                    cur = 8'($urandom_range(1, 255));
                end
                finished = r.message_done;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // One random phase: settings, traffic mix and idling per phase index.
    // Extreme settings sit in fixed phases; the rest are drawn.
    // ------------------------------------------------------------------
    task automatic run_phase(int p);
        cfg_t  c;
        mix_t  mix;
        step_t s;
        res_t  r;
        int    len, zero_odds, mid, stop, roll;
        bit    paused;
        c.header_enable = 1'($urandom_range(0, 1));
        c.header_value  = 8'($urandom_range(0, 255));
        c.footer_enable = 1'($urandom_range(0, 1));
        c.footer_value  = 8'($urandom_range(0, 255));
        c.line_limit    = 8'($urandom_range(1, 255));
        mix       = MIX_NOISE;
        len       = 100;
        zero_odds = 8;
        case (p)
            0: begin
                mix = MIX_MESSAGES; len = 120;
                c.header_enable = 1'b1; c.header_value = 8'h00;
                c.footer_enable = 1'b1; c.footer_value = 8'hFF;
                c.line_limit = LINE_LIMIT_RESET;
            end
            1: begin
                mix = MIX_TX_FLOOD; len = 120;
                c.header_enable = 1'b1; c.header_value = 8'hFF;
                c.footer_enable = 1'b1; c.footer_value = 8'h00;
            end
            2: begin
                // long lines, rarely ended by a zero byte and mostly cut by the next phase
                mix = MIX_LINES; len = 100; zero_odds = 64;
                c.header_enable = 1'b0; c.footer_enable = 1'b0;
                c.line_limit = 8'd255;
            end
            3: begin
                // limit drops below a partly filled line
                mix = MIX_LINES; len = 60;
                c.line_limit = 8'd3;
            end
            4: begin
                mix = MIX_RX_FLOOD; len = 100;
                c.line_limit = 8'd0;
            end
            5: begin
                // limit zero and no terminators: lines run to 255 bytes
                mix = MIX_LINES; len = 560; zero_odds = 0;
                c.line_limit = 8'd0;
            end
            6: begin
                mix = MIX_NOISE; len = 100;
            end
            7: begin
                mix = MIX_TX_FLOOD; len = 80;
                c.header_enable = 1'b0; c.footer_enable = 1'b1;
            end
            8: begin
                mix = MIX_MESSAGES; len = 80;
                c.header_enable = 1'b1; c.footer_enable = 1'b0;
                c.line_limit = 8'd1;
            end
            default: begin
                mix = MIX_NOISE; len = 80;
                c.line_limit = 8'd2;
            end
        endcase

        drain_results();
        write_settings(c);
        in_idle  = (p % 3 != 2);
        out_idle = (p % 4 != 3);
        mid    = items_sent + len / 2;
        stop   = items_sent + len;
        paused = 1'b0;

        while (items_sent < stop) begin
            // once per phase the sender holds off until the block is empty
            if (!paused && items_sent >= mid) begin
                drain_results();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_MESSAGES: begin
                    if (roll < 60)
                        send_message($urandom_range(0, 12), 30, 80, stop);
                    else if (roll < 75)
                        push_item(random_step(CMD_SERVICE), r);
                    else if (roll < 88)
                        push_item(random_step(CMD_READ), r);
                    else
                        push_item(random_step(CMD_LINE), r);
                end
                MIX_TX_FLOOD: begin
                    if (roll < 75)
                        send_message($urandom_range(0, 40), 15, 10, stop);
                    else
                        push_item(random_step(CMD_SERVICE), r);
                end
                MIX_RX_FLOOD: begin
                    if (roll < 85) begin
                        s          = random_step(CMD_SERVICE);
                        s.rx_ready = 1'b1;
                    end else if (roll < 93) begin
                        s = random_step(CMD_LINE);
                    end else begin
                        s = random_step(CMD_READ);
                    end
                    push_item(s, r);
                end
                MIX_LINES: begin
                    if (roll < 50) begin
                        s          = random_step(CMD_SERVICE);
                        s.rx_ready = 1'b1;
                        if (zero_odds != 0 && $urandom_range(1, zero_odds) == 1)
                            s.rx_byte = 8'd0;
                        else
                            s.rx_byte = 8'($urandom_range(1, 255));
                    end else if (roll < 95) begin
                        s = random_step(CMD_LINE);
                    end else begin
                        s = random_step(CMD_READ);
                    end
                    push_item(s, r);
                end
                default: push_item(random_step(cmd_t'($urandom_range(0, 3))), r);
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_t c;
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: reads on an empty ring, a service with nothing to
        // transmit (busy stays clear), then bytes at both extremes.
        direct(CMD_READ,    8'hFF, 1'b1, 8'hFF, 1'b1);
        direct(CMD_LINE,    8'h00, 1'b0, 8'h00, 1'b0);
        direct(CMD_SERVICE, 8'h00, 1'b1, 8'hFF, 1'b1);
        direct(CMD_SERVICE, 8'hFF, 1'b1, 8'h00, 1'b0);
        direct(CMD_SERVICE, 8'h80, 1'b1, 8'h5A, 1'b0);
        direct(CMD_READ,    8'h00, 1'b0, 8'h00, 1'b0);
        direct(CMD_LINE,    8'h00, 1'b0, 8'h00, 1'b0);   // zero byte ends the line
        direct(CMD_LINE,    8'h00, 1'b0, 8'h00, 1'b0);   // leaves one byte counted

        // Header and footer on, limit 2: a full framed message, then a running
        // line count that already makes the line full.
        drain_results();
        c = '{header_enable: 1'b1, header_value: 8'hFF, footer_enable: 1'b1,
              footer_value: 8'h00, line_limit: 8'd2};
        write_settings(c);
        direct(CMD_SEND,    8'h41, 1'b0, 8'h00, 1'b0);   // header goes first
        direct(CMD_SEND,    8'h41, 1'b1, 8'hFF, 1'b1);
        direct(CMD_SEND,    8'hFF, 1'b0, 8'h00, 1'b0);
        direct(CMD_SEND,    8'h00, 1'b0, 8'h00, 1'b0);   // footer
        direct(CMD_SEND,    8'h00, 1'b0, 8'h00, 1'b0);   // done report
        repeat (5) direct(CMD_SERVICE, 8'h00, 1'b0, 8'h00, 1'b1);
        direct(CMD_SERVICE, 8'h00, 1'b1, 8'h80, 1'b0);
        direct(CMD_SERVICE, 8'h00, 1'b1, 8'h7F, 1'b0);
        direct(CMD_LINE,    8'h00, 1'b0, 8'h00, 1'b0);
        direct(CMD_LINE,    8'h00, 1'b0, 8'h00, 1'b0);

        for (int p = 0; p < PHASE_COUNT; p++)
            run_phase(p);

        drain_results();
        repeat (SETTLE_TAIL) @(posedge clk);

        $display("covered %0d steps: %0d send, %0d service, %0d line, %0d read",
                 items_sent, steps_of[CMD_SEND], steps_of[CMD_SERVICE],
                 steps_of[CMD_LINE], steps_of[CMD_READ]);
        $display("%0d checked, %0d messages, %0d to tx, %0d refused, %0d drops, %0d lines",
                 board.checked, board.messages_ended, board.tx_handed,
                 board.tx_refusals, board.rx_drops, board.lines_ended);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     board.mismatches, board.pending());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* framed_uart_byte_buffer_top.f */
rtl/ufb_pkg.sv
rtl/ufb_front.sv
rtl/ufb_back.sv
rtl/framed_uart_byte_buffer_top.sv
bench/framed_uart_byte_buffer_tb.sv
